>>> hw/rtl/sld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'h55;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'hDA;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT1   = 2'd0,
        PH_HUNT2   = 2'd1,
        PH_LEN     = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] first_sync;
        logic [BYTE_W-1:0] second_sync;
    } t_sync_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_frame;
        logic              empty_frame;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/sld_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sld_cfg_regs
    import sld_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    output t_sync_cfg                 o_cfg
);

    t_sync_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_sync  <= FIRST_SYNC_RESET;
            r_cfg.second_sync <= SECOND_SYNC_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIRST_SYNC:  r_cfg.first_sync  <= i_cfg_data;
                CFG_SECOND_SYNC: r_cfg.second_sync <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/sld_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sld_in_stage
    import sld_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic                   o_stall,
    input  wire logic              i_advance,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              take;

    // The held beat leaves whenever the parser advances, so a new beat can
    // enter in the same cycle.
    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

>>> hw/rtl/sld_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module sld_parser
    import sld_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_sync_cfg         i_cfg,
    input  wire logic              i_valid,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic                   o_advance,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output t_result                o_result
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_remaining, n_remaining;
    logic              r_out_valid;
    t_result           r_out, n_out;
    logic              n_emit;
    logic              step;

    assign o_advance = !r_out_valid || !i_stall;
    assign step      = i_valid && o_advance;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_emit      = 1'b0;
        n_out       = '0;
        case (r_phase)
            PH_HUNT1: begin
                if (i_byte == i_cfg.first_sync) begin
                    n_phase = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                // A repeated first sync byte keeps the partial match.
                if (i_byte == i_cfg.second_sync) begin
                    n_phase = PH_LEN;
                end else if (i_byte != i_cfg.first_sync) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_LEN: begin
                if (i_byte == '0) begin
                    n_emit              = 1'b1;
                    n_out.last_of_frame = 1'b1;
                    n_out.empty_frame   = 1'b1;
                    n_phase             = PH_HUNT1;
                end else begin
                    n_remaining = i_byte;
                    n_phase     = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_emit             = 1'b1;
                n_out.payload_byte = i_byte;
                if (r_remaining <= BYTE_W'(1)) begin
                    n_out.last_of_frame = 1'b1;
                    n_remaining         = '0;
                    n_phase             = PH_HUNT1;
                end else begin
                    n_remaining = r_remaining - BYTE_W'(1);
                end
            end
            default: begin
                n_phase = PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT1;
            r_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
            end
            if (o_advance) begin
                r_out_valid <= i_valid && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.empty_frame |-> r_out.last_of_frame && r_out.payload_byte == '0)
        else $error("empty frame result not marked last or has payload");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remaining != '0)
        else $error("payload phase with no bytes remaining");

    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT1 || r_phase == PH_HUNT2) |-> r_remaining == '0)
        else $error("remaining count nonzero while hunting");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_phase == PH_LEN && i_byte == '0
        |=> r_out_valid && r_out.empty_frame && r_phase == PH_HUNT1)
        else $error("zero length did not give an empty frame result");

endmodule

`default_nettype wire

>>> hw/rtl/sync_length_deframer_top.sv
// Two-byte sync, length-prefixed deframer. Received bytes enter one beat per
// cycle unless stalled; the block hunts for first_sync followed by second_sync
// (a repeated first sync byte keeps the partial match), takes the next byte
// as a payload length of 0 to 255 and passes that many following bytes out,
// marking the last. A zero length gives one result with empty_frame and
// last_of_frame set. All other bytes give no result. Each beat goes through
// an input register and a result register; one byte per cycle is sustained
// while the output is not stalled. Sync values are written through the config
// port (index 0 first sync, index 1 second sync) by the user only while the
// block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_deframer_top
    import sld_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_rx_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [7:0]                o_payload_byte,
    output logic                      o_last_of_frame,
    output logic                      o_empty_frame,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    t_sync_cfg         cfg;
    t_result           result;
    logic              advance;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;

    assign o_cfg_ready = 1'b1;

    sld_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sld_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_byte    (i_rx_byte),
        .o_stall   (o_in_stall),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    sld_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (in_valid),
        .i_byte    (in_byte),
        .o_advance (advance),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_result  (result)
    );

    assign o_payload_byte  = result.payload_byte;
    assign o_last_of_frame = result.last_of_frame;
    assign o_empty_frame   = result.empty_frame;

endmodule

`default_nettype wire
